// File: rtl/gamma_doppler_correction_unit_defines.svh
// Assertion helpers for the RTL of the Doppler correction block.
`ifndef GAMMA_DOPPLER_CORRECTION_UNIT_DEFINES_SVH
`define GAMMA_DOPPLER_CORRECTION_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdc check failed");

// Next-cycle implication, checked out of reset.
`define GDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdc check failed");

`endif

// File: rtl/gdc_pkg.sv
package gdc_pkg;

    // Fixed field widths.
    localparam int BETA_BITS   = 15;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int OUT_BITS    = 24;
    localparam int STATUS_BITS = 2;
    localparam int SHIFT_BITS  = 16;
    localparam int NORM_BITS   = 32;
    localparam int COS_BITS    = 17;
    localparam int NUM_BITS    = 31;
    localparam int GARG_BITS   = 62;
    localparam int G_BITS      = 31;

    localparam logic [BETA_BITS-1:0] BETA_RESET = 15'd19661;
    localparam logic [BETA_BITS-1:0] BETA_MAX   = 15'd32767;
    localparam logic [COS_BITS-1:0]  COS_ONE    = 17'd32768;
    localparam logic [OUT_BITS-1:0]  OUT_MAX    = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BETA_MEAN     = 2'd0,
        CFG_BETA_TOF_MEAN = 2'd1,
        CFG_DECAY_SHIFT_Z = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

endpackage

// File: rtl/gdc_channels.sv
// Hit channel: one detector hit per transfer.
interface gdc_hit_if #(
    parameter int POSITION_BITS = 16,
    parameter int ENERGY_BITS   = 20
) ();
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] crystal_x;
    logic signed [POSITION_BITS-1:0] crystal_y;
    logic signed [POSITION_BITS-1:0] crystal_z;
    logic signed [POSITION_BITS-1:0] vertex_x;
    logic signed [POSITION_BITS-1:0] vertex_y;
    logic signed [POSITION_BITS-1:0] vertex_z;
    logic signed [POSITION_BITS-1:0] track_x;
    logic signed [POSITION_BITS-1:0] track_y;
    logic signed [POSITION_BITS-1:0] track_z;
    logic [ENERGY_BITS-1:0]          lab_energy;
    logic [gdc_pkg::BETA_BITS-1:0]   beta_measured;

    modport source (
        output valid, crystal_x, crystal_y, crystal_z, vertex_x, vertex_y, vertex_z,
               track_x, track_y, track_z, lab_energy, beta_measured,
        input  ready
    );
    modport sink (
        input  valid, crystal_x, crystal_y, crystal_z, vertex_x, vertex_y, vertex_z,
               track_x, track_y, track_z, lab_energy, beta_measured,
        output ready
    );
endinterface

// Result channel: one corrected energy per transfer.
interface gdc_res_if ();
    logic                            valid;
    logic                            ready;
    logic [gdc_pkg::OUT_BITS-1:0]    corrected_energy;
    logic [gdc_pkg::STATUS_BITS-1:0] status;

    modport source (output valid, corrected_energy, status, input ready);
    modport sink (input valid, corrected_energy, status, output ready);
endinterface

// File: rtl/gamma_doppler_correction_unit.sv
// Relativistic Doppler correction of gamma detector hits.
// A hit enters on i_hit (crystal, vertex and track positions, measured energy,
// event beta) and one result leaves on o_res (corrected energy, status) per hit.
// Both channels use valid/ready; a transfer happens when both are high.
// Configuration registers (beta_mean, beta_tof_mean, decay_shift_z) are written
// through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while no
// hit is in flight, which the block itself does not enforce. Throughput is one
// hit per clock while o_res is not stalled. A hit passes 114 register stages:
// four vector stages, a 32-stage square root for the norm product, a rounding
// stage, a 17-stage cosine divider, two beta stages, a 31-stage square root for
// the Lorentz factor, two product stages, a 24-stage energy divider and the
// output register.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and i_hit.ready drops; nothing is dropped or repeated.
// Reset empties the pipeline and loads the register defaults
// (beta_mean = beta_tof_mean = 19661, decay_shift_z = 0).
`include "gamma_doppler_correction_unit_defines.svh"
module gamma_doppler_correction_unit #(
    parameter int POSITION_BITS = 16,
    parameter int ENERGY_BITS   = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gdc_hit_if.sink                           i_hit,
    gdc_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [gdc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [gdc_pkg::CFG_BITS-1:0]      i_cfg_data
);
    localparam int AW   = (POSITION_BITS > 16 ? POSITION_BITS : 16) + 2;
    localparam int SW   = $clog2(AW);
    localparam int EB   = ENERGY_BITS;
    localparam int EPW  = EB + gdc_pkg::NUM_BITS;
    localparam int NW2  = EPW + 1;
    localparam int GSW  = gdc_pkg::G_BITS + gdc_pkg::OUT_BITS;
    localparam int CW   = (NW2 > GSW) ? NW2 : GSW;
    localparam int BB   = gdc_pkg::BETA_BITS;

    typedef struct packed {
        logic [gdc_pkg::NORM_BITS-1:0] dot_mag;
        logic                          dot_neg;
        logic [BB-1:0]                 beta;
        logic [EB-1:0]                 energy;
        logic                          zero;
        logic                          clamp;
    } t_root1_pl;

    typedef struct packed {
        logic [EB-1:0] energy;
        logic          zero;
        logic          clamp;
    } t_tail_pl;

    typedef struct packed {
        logic [gdc_pkg::NUM_BITS-1:0] num;
        logic [EB-1:0]                energy;
        logic                         zero;
        logic                         clamp;
    } t_root2_pl;

    typedef struct packed {
        logic zero;
        logic clamp;
        logic sat;
    } t_out_pl;

    // Configuration registers.
    logic [BB-1:0]                          r_beta_mean;
    logic [BB-1:0]                          r_beta_tof;
    logic signed [gdc_pkg::SHIFT_BITS-1:0]  r_shift_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_mean <= gdc_pkg::BETA_RESET;
            r_beta_tof  <= gdc_pkg::BETA_RESET;
            r_shift_z   <= '0;
        end else if (i_cfg_we) begin
            unique case (gdc_pkg::t_cfg_idx'(i_cfg_idx))
                gdc_pkg::CFG_BETA_MEAN:     r_beta_mean <= i_cfg_data[BB-1:0];
                gdc_pkg::CFG_BETA_TOF_MEAN: r_beta_tof  <= i_cfg_data[BB-1:0];
                gdc_pkg::CFG_DECAY_SHIFT_Z: r_shift_z   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result is waiting on a stalled sink.
    logic w_en;
    logic r_out_valid;
    assign w_en        = !r_out_valid || o_res.ready;
    assign i_hit.ready = w_en;

    // Stage 1: difference vectors, effective beta, zero-length check.
    logic signed [AW-1:0] w_a [3];
    logic signed [AW-1:0] w_b [3];
    logic signed [17:0]   w_beta_sum;
    logic [BB-1:0]        w_beta;
    logic                 w_clamp;
    logic                 w_zero;

    always_comb begin
        w_a[0] = AW'(i_hit.crystal_x) - AW'(i_hit.vertex_x);
        w_a[1] = AW'(i_hit.crystal_y) - AW'(i_hit.vertex_y);
        w_a[2] = AW'(i_hit.crystal_z) - AW'(i_hit.vertex_z) - AW'(r_shift_z);
        w_b[0] = AW'(i_hit.track_x) - AW'(i_hit.vertex_x);
        w_b[1] = AW'(i_hit.track_y) - AW'(i_hit.vertex_y);
        w_b[2] = AW'(i_hit.track_z) - AW'(i_hit.vertex_z);
        w_zero = (w_a[0] == '0 && w_a[1] == '0 && w_a[2] == '0) ||
                 (w_b[0] == '0 && w_b[1] == '0 && w_b[2] == '0);
        w_beta_sum = $signed({3'b000, r_beta_mean}) + $signed({3'b000, i_hit.beta_measured})
                   - $signed({3'b000, r_beta_tof});
        priority if (w_beta_sum < 0) begin
            w_beta  = '0;
            w_clamp = 1'b1;
        end else if (w_beta_sum > 18'sd32767) begin
            w_beta  = gdc_pkg::BETA_MAX;
            w_clamp = 1'b1;
        end else begin
            w_beta  = w_beta_sum[BB-1:0];
            w_clamp = 1'b0;
        end
    end

    logic                 r_s1_valid;
    logic signed [AW-1:0] r_s1_a [3];
    logic signed [AW-1:0] r_s1_b [3];
    logic [BB-1:0]        r_s1_beta;
    logic [EB-1:0]        r_s1_energy;
    logic                 r_s1_zero;
    logic                 r_s1_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_hit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_a      <= w_a;
            r_s1_b      <= w_b;
            r_s1_beta   <= w_beta;
            r_s1_energy <= i_hit.lab_energy;
            r_s1_zero   <= w_zero;
            r_s1_clamp  <= w_clamp;
        end
    end

    // Stage 2: scale each vector so its largest magnitude fits in 15 bits.
    function automatic logic [AW-1:0] mag_of(input logic signed [AW-1:0] v);
        return v[AW-1] ? AW'(~v + 1'b1) : AW'(v);
    endfunction

    function automatic logic [SW-1:0] shift_of(input logic [AW-1:0] m);
        logic [SW-1:0] s;
        s = '0;
        for (int i = 15; i < AW; i++) begin
            if (m[i]) s = SW'(i - 14);
        end
        return s;
    endfunction

    function automatic logic signed [15:0] scale_comp(input logic signed [AW-1:0] v,
                                                      input logic [SW-1:0] s);
        logic [AW-1:0]        q;
        logic signed [15:0]   m;
        q = mag_of(v) >> s;
        m = $signed({1'b0, q[14:0]});
        return v[AW-1] ? -m : m;
    endfunction

    logic [SW-1:0] w_sa;
    logic [SW-1:0] w_sb;
    assign w_sa = shift_of(mag_of(r_s1_a[0]) | mag_of(r_s1_a[1]) | mag_of(r_s1_a[2]));
    assign w_sb = shift_of(mag_of(r_s1_b[0]) | mag_of(r_s1_b[1]) | mag_of(r_s1_b[2]));

    logic               r_s2_valid;
    logic signed [15:0] r_s2_a [3];
    logic signed [15:0] r_s2_b [3];
    logic [BB-1:0]      r_s2_beta;
    logic [EB-1:0]      r_s2_energy;
    logic               r_s2_zero;
    logic               r_s2_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_a[i] <= scale_comp(r_s1_a[i], w_sa);
                r_s2_b[i] <= scale_comp(r_s1_b[i], w_sb);
            end
            r_s2_beta   <= r_s1_beta;
            r_s2_energy <= r_s1_energy;
            r_s2_zero   <= r_s1_zero;
            r_s2_clamp  <= r_s1_clamp;
        end
    end

    // Stage 3: squared norms and dot product.
    logic signed [33:0] w_ea [3];
    logic signed [33:0] w_eb [3];
    logic signed [33:0] w_n1;
    logic signed [33:0] w_n2;
    logic signed [33:0] w_dot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ea[i] = 34'(r_s2_a[i]);
            w_eb[i] = 34'(r_s2_b[i]);
        end
        w_n1  = w_ea[0] * w_ea[0] + w_ea[1] * w_ea[1] + w_ea[2] * w_ea[2];
        w_n2  = w_eb[0] * w_eb[0] + w_eb[1] * w_eb[1] + w_eb[2] * w_eb[2];
        w_dot = w_ea[0] * w_eb[0] + w_ea[1] * w_eb[1] + w_ea[2] * w_eb[2];
    end

    logic                          r_s3_valid;
    logic [gdc_pkg::NORM_BITS-1:0] r_s3_n1;
    logic [gdc_pkg::NORM_BITS-1:0] r_s3_n2;
    logic signed [32:0]            r_s3_dot;
    logic [BB-1:0]                 r_s3_beta;
    logic [EB-1:0]                 r_s3_energy;
    logic                          r_s3_zero;
    logic                          r_s3_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_n1     <= w_n1[31:0];
            r_s3_n2     <= w_n2[31:0];
            r_s3_dot    <= w_dot[32:0];
            r_s3_beta   <= r_s2_beta;
            r_s3_energy <= r_s2_energy;
            r_s3_zero   <= r_s2_zero;
            r_s3_clamp  <= r_s2_clamp;
        end
    end

    // Stage 4: product of the squared norms and the dot magnitude.
    logic        r_s4_valid;
    logic [63:0] r_s4_prod;
    t_root1_pl   r_s4_pl;
    logic [32:0] w_dot_abs;

    assign w_dot_abs = r_s3_dot[32] ? 33'(-r_s3_dot) : 33'(r_s3_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_prod       <= 64'(r_s3_n1) * 64'(r_s3_n2);
            r_s4_pl.dot_mag <= w_dot_abs[31:0];
            r_s4_pl.dot_neg <= r_s3_dot[32];
            r_s4_pl.beta    <= r_s3_beta;
            r_s4_pl.energy  <= r_s3_energy;
            r_s4_pl.zero    <= r_s3_zero;
            r_s4_pl.clamp   <= r_s3_clamp;
        end
    end

    // Denominator: floor(sqrt(n1 * n2)).
    logic                          w_r1_valid;
    logic [gdc_pkg::NORM_BITS-1:0] w_r1_den;
    t_root1_pl                     w_r1_pl;

    gdc_isqrt_pipe #(
        .W  (64),
        .PW ($bits(t_root1_pl))
    ) u_norm_root (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_s4_valid),
        .i_arg     (r_s4_prod),
        .i_payload (r_s4_pl),
        .o_valid   (w_r1_valid),
        .o_root    (w_r1_den),
        .o_payload (w_r1_pl)
    );

    // Stage 5: rounded cosine dividend.
    logic                          r_s5_valid;
    logic [47:0]                   r_s5_num;
    logic [gdc_pkg::NORM_BITS-1:0] r_s5_den;
    t_root1_pl                     r_s5_pl;
    logic [gdc_pkg::NORM_BITS-1:0] w_den;

    assign w_den = (w_r1_den == '0) ? 32'd1 : w_r1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= w_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_num <= {1'b0, w_r1_pl.dot_mag, 15'd0} + 48'(w_den >> 1);
            r_s5_den <= w_den;
            r_s5_pl  <= w_r1_pl;
        end
    end

    logic                         w_d1_valid;
    logic [gdc_pkg::COS_BITS-1:0] w_d1_q;
    t_root1_pl                    w_d1_pl;

    gdc_div_pipe #(
        .NW (48),
        .DW (gdc_pkg::NORM_BITS),
        .QB (gdc_pkg::COS_BITS),
        .PW ($bits(t_root1_pl))
    ) u_cos_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_s5_valid),
        .i_num     (r_s5_num),
        .i_den     (r_s5_den),
        .i_payload (r_s5_pl),
        .o_valid   (w_d1_valid),
        .o_quo     (w_d1_q),
        .o_payload (w_d1_pl)
    );

    // Stage 6: beta * cos and beta squared.
    logic [gdc_pkg::COS_BITS-1:0] w_qc;
    logic signed [33:0]           w_c;
    logic signed [33:0]           w_bs;

    always_comb begin
        w_qc = (w_d1_q > gdc_pkg::COS_ONE) ? gdc_pkg::COS_ONE : w_d1_q;
        w_c  = w_d1_pl.dot_neg ? -34'(w_qc) : 34'(w_qc);
        w_bs = 34'(w_d1_pl.beta);
    end

    logic               r_s6_valid;
    logic signed [33:0] r_s6_bc;
    logic [29:0]        r_s6_bb;
    t_tail_pl           r_s6_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (w_en) begin
            r_s6_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_bc        <= w_bs * w_c;
            r_s6_bb        <= 30'(w_d1_pl.beta) * 30'(w_d1_pl.beta);
            r_s6_pl.energy <= w_d1_pl.energy;
            r_s6_pl.zero   <= w_d1_pl.zero;
            r_s6_pl.clamp  <= w_d1_pl.clamp;
        end
    end

    // Stage 7: numerator 1 - beta*cos in Q.30 and the Lorentz root argument in Q.60.
    logic signed [33:0] w_num;
    logic [30:0]        w_gbase;

    assign w_num   = 34'sh40000000 - r_s6_bc;
    assign w_gbase = 31'h40000000 - 31'(r_s6_bb);

    logic                          r_s7_valid;
    logic [gdc_pkg::GARG_BITS-1:0] r_s7_garg;
    t_root2_pl                     r_s7_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (w_en) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_garg      <= {1'b0, w_gbase, 30'd0};
            r_s7_pl.num    <= w_num[gdc_pkg::NUM_BITS-1:0];
            r_s7_pl.energy <= r_s6_pl.energy;
            r_s7_pl.zero   <= r_s6_pl.zero;
            r_s7_pl.clamp  <= r_s6_pl.clamp;
        end
    end

    logic                       w_r2_valid;
    logic [gdc_pkg::G_BITS-1:0] w_r2_g;
    t_root2_pl                  w_r2_pl;

    gdc_isqrt_pipe #(
        .W  (gdc_pkg::GARG_BITS),
        .PW ($bits(t_root2_pl))
    ) u_gamma_root (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_s7_valid),
        .i_arg     (r_s7_garg),
        .i_payload (r_s7_pl),
        .o_valid   (w_r2_valid),
        .o_root    (w_r2_g),
        .o_payload (w_r2_pl)
    );

    // Stage 8: energy times numerator.
    logic                       r_s8_valid;
    logic [EPW-1:0]             r_s8_prod;
    logic [gdc_pkg::G_BITS-1:0] r_s8_g;
    logic                       r_s8_zero;
    logic                       r_s8_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (w_en) begin
            r_s8_valid <= w_r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_prod  <= EPW'(w_r2_pl.energy) * EPW'(w_r2_pl.num);
            r_s8_g     <= w_r2_g;
            r_s8_zero  <= w_r2_pl.zero;
            r_s8_clamp <= w_r2_pl.clamp;
        end
    end

    // Stage 9: rounded dividend and the 24-bit overflow check.
    logic [NW2-1:0] w_n2e;
    logic           w_sat;

    assign w_n2e = NW2'(r_s8_prod) + NW2'(r_s8_g >> 1);
    assign w_sat = CW'(w_n2e) >= (CW'(r_s8_g) << gdc_pkg::OUT_BITS);

    logic                       r_s9_valid;
    logic [NW2-1:0]             r_s9_num;
    logic [gdc_pkg::G_BITS-1:0] r_s9_g;
    t_out_pl                    r_s9_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (w_en) begin
            r_s9_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_num      <= w_n2e;
            r_s9_g        <= r_s8_g;
            r_s9_pl.zero  <= r_s8_zero;
            r_s9_pl.clamp <= r_s8_clamp;
            r_s9_pl.sat   <= w_sat;
        end
    end

    logic                         w_d2_valid;
    logic [gdc_pkg::OUT_BITS-1:0] w_d2_q;
    t_out_pl                      w_d2_pl;

    gdc_div_pipe #(
        .NW (NW2),
        .DW (gdc_pkg::G_BITS),
        .QB (gdc_pkg::OUT_BITS),
        .PW ($bits(t_out_pl))
    ) u_energy_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_s9_valid),
        .i_num     (r_s9_num),
        .i_den     (r_s9_g),
        .i_payload (r_s9_pl),
        .o_valid   (w_d2_valid),
        .o_quo     (w_d2_q),
        .o_payload (w_d2_pl)
    );

    // Output register: special cases override the quotient.
    logic [gdc_pkg::OUT_BITS-1:0] r_out_energy;
    gdc_pkg::t_status             r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (w_d2_pl.zero) begin
                r_out_energy <= '0;
                r_out_status <= gdc_pkg::ST_ZERO;
            end else if (w_d2_pl.sat) begin
                r_out_energy <= gdc_pkg::OUT_MAX;
                r_out_status <= gdc_pkg::ST_SAT;
            end else begin
                r_out_energy <= w_d2_q;
                r_out_status <= w_d2_pl.clamp ? gdc_pkg::ST_SAT : gdc_pkg::ST_OK;
            end
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.corrected_energy = r_out_energy;
    assign o_res.status           = r_out_status;

    // A zero-length result always carries zero energy.
    `GDC_ASSERT_IMP(a_zero_result, r_out_valid && r_out_status == gdc_pkg::ST_ZERO, r_out_energy == '0)
    // The rounded cosine never exceeds one.
    `GDC_ASSERT_IMP(a_cos_range, w_d1_valid, w_d1_q <= gdc_pkg::COS_ONE)
    // The numerator and the Lorentz root argument stay positive.
    `GDC_ASSERT_IMP(a_num_positive, r_s7_valid, r_s7_pl.num != '0 && r_s7_garg != '0)
    // A stall freezes the pipeline entry.
    `GDC_ASSERT_NXT(a_stall_hold, !w_en, $stable(r_s1_valid))
endmodule

// File: rtl/gdc_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module gdc_isqrt_pipe #(
    parameter int W  = 64,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W-1:0]    i_arg,
    input  logic [PW-1:0]   i_payload,
    output logic            o_valid,
    output logic [W/2-1:0]  o_root,
    output logic [PW-1:0]   o_payload
);
    localparam int S = W / 2;

    logic          r_valid [S];
    logic [W-1:0]  r_rem   [S];
    logic [W-1:0]  r_root  [S];
    logic [PW-1:0] r_pl    [S];
    logic [W-1:0]  n_rem   [S];
    logic [W-1:0]  n_root  [S];

    // Each stage tries one bit pair of the remainder.
    always_comb begin
        logic [W-1:0] p_rem;
        logic [W-1:0] p_root;
        logic [W-1:0] bitv;
        logic [W-1:0] trial;
        for (int k = 0; k < S; k++) begin
            p_rem  = (k == 0) ? i_arg : r_rem[(k == 0) ? 0 : k-1];
            p_root = (k == 0) ? '0 : r_root[(k == 0) ? 0 : k-1];
            bitv   = W'(1) << (2 * (S - 1 - k));
            trial  = p_root + bitv;
            if (p_rem >= trial) begin
                n_rem[k]  = p_rem - trial;
                n_root[k] = (p_root >> 1) + bitv;
            end else begin
                n_rem[k]  = p_rem;
                n_root[k] = p_root >> 1;
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) r_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < S; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl[0] <= i_payload;
            for (int k = 1; k < S; k++) r_pl[k] <= r_pl[k-1];
            for (int k = 0; k < S; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_valid   = r_valid[S-1];
    assign o_root    = r_root[S-1][S-1:0];
    assign o_payload = r_pl[S-1];
endmodule

// File: rtl/gdc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The quotient must fit in QB bits; callers guarantee or override that.
module gdc_div_pipe #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QB = 17,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_payload,
    output logic          o_valid,
    output logic [QB-1:0] o_quo,
    output logic [PW-1:0] o_payload
);
    localparam int XW = (NW > DW + QB) ? NW : DW + QB;

    logic          r_valid [QB];
    logic [XW-1:0] r_rem   [QB];
    logic [DW-1:0] r_den   [QB];
    logic [QB-1:0] r_quo   [QB];
    logic [PW-1:0] r_pl    [QB];
    logic [XW-1:0] n_rem   [QB];
    logic [QB-1:0] n_quo   [QB];

    // Each stage compares against the divisor shifted to its quotient bit.
    always_comb begin
        logic [XW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [QB-1:0] p_quo;
        logic [XW-1:0] shifted;
        for (int k = 0; k < QB; k++) begin
            p_rem   = (k == 0) ? XW'(i_num) : r_rem[(k == 0) ? 0 : k-1];
            p_den   = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
            p_quo   = (k == 0) ? '0 : r_quo[(k == 0) ? 0 : k-1];
            shifted = XW'(p_den) << (QB - 1 - k);
            if (p_rem >= shifted) begin
                n_rem[k] = p_rem - shifted;
                n_quo[k] = p_quo | (QB'(1) << (QB - 1 - k));
            end else begin
                n_rem[k] = p_rem;
                n_quo[k] = p_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) r_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < QB; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_pl[0]  <= i_payload;
            for (int k = 1; k < QB; k++) begin
                r_den[k] <= r_den[k-1];
                r_pl[k]  <= r_pl[k-1];
            end
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_valid   = r_valid[QB-1];
    assign o_quo     = r_quo[QB-1];
    assign o_payload = r_pl[QB-1];
endmodule

// File: tb/sv/tb.sv
module tb;

    localparam int POS_W       = 16;
    localparam int EN_W        = 20;
    localparam int BETA_W      = gdc_pkg::BETA_BITS;
    localparam int CFG_W       = gdc_pkg::CFG_BITS;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [POS_W-1:0] cx, cy, cz, vx, vy, vz, tx, ty, tz;
        logic [EN_W-1:0]         energy;
        logic [BETA_W-1:0]       beta;
    } t_hit;

    typedef struct {
        logic [gdc_pkg::OUT_BITS-1:0] energy;
        gdc_pkg::t_status             status;
    } t_corr;

    typedef longint t_vec3 [3];

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [gdc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_W-1:0]                 i_cfg_data;

    gdc_hit_if #(.POSITION_BITS(POS_W), .ENERGY_BITS(EN_W)) hit_ch ();
    gdc_res_if res_ch ();

    gamma_doppler_correction_unit #(.POSITION_BITS(POS_W), .ENERGY_BITS(EN_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hit      (hit_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the configuration registers.
    logic [BETA_W-1:0]                     mean_beta;
    logic [BETA_W-1:0]                     tof_beta;
    logic signed [gdc_pkg::SHIFT_BITS-1:0] z_shift;

    t_hit  pending_hits [$];
    t_corr expected_corr [$];
    t_hit  hit_on_bus;
    bit    steady;
    bit    hold_hits;
    int    errors;
    int    hits_sent;
    int    results_seen;
    int    zero_seen;
    int    sat_seen;
    int    quiet_cycles;

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Shift a vector right until every component magnitude fits in 15 bits.
    function automatic t_vec3 shrink_vec(input t_vec3 v);
        longint unsigned top;
        int sh;
        t_vec3 r;
        top = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) if (magnitude(v[i]) > top) top = magnitude(v[i]);
        while ((top >> sh) >= 32768) sh++;
        for (int i = 0; i < 3; i++) begin
            r[i] = longint'(magnitude(v[i]) >> sh);
            if (v[i] < 0) r[i] = -r[i];
        end
        return r;
    endfunction

    // Doppler corrected energy of one hit under the current configuration.
    function automatic t_corr doppler_correct(input t_hit h);
        t_vec3 ga, bm;
        longint unsigned n1, n2, den, q, g, res;
        longint dot, cosv, num, beta;
        t_corr r;
        r.status = gdc_pkg::ST_OK;
        ga[0] = longint'(h.cx) - longint'(h.vx);
        ga[1] = longint'(h.cy) - longint'(h.vy);
        ga[2] = longint'(h.cz) - longint'(h.vz) - longint'(z_shift);
        bm[0] = longint'(h.tx) - longint'(h.vx);
        bm[1] = longint'(h.ty) - longint'(h.vy);
        bm[2] = longint'(h.tz) - longint'(h.vz);
        if ((ga[0] == 0 && ga[1] == 0 && ga[2] == 0) ||
            (bm[0] == 0 && bm[1] == 0 && bm[2] == 0)) begin
            r.energy = '0;
            r.status = gdc_pkg::ST_ZERO;
            return r;
        end
        ga = shrink_vec(ga);
        bm = shrink_vec(bm);
        n1 = ga[0] * ga[0] + ga[1] * ga[1] + ga[2] * ga[2];
        n2 = bm[0] * bm[0] + bm[1] * bm[1] + bm[2] * bm[2];
        dot = ga[0] * bm[0] + ga[1] * bm[1] + ga[2] * bm[2];
        den = int_sqrt(n1 * n2);
        if (den == 0) den = 1;
        q = ((magnitude(dot) << 15) + den / 2) / den;
        if (q > 32768) q = 32768;
        cosv = (dot < 0) ? -longint'(q) : longint'(q);
        beta = longint'({1'b0, mean_beta}) + longint'({1'b0, h.beta})
             - longint'({1'b0, tof_beta});
        if (beta < 0) begin
            beta = 0;
            r.status = gdc_pkg::ST_SAT;
        end
        if (beta > 32767) begin
            beta = 32767;
            r.status = gdc_pkg::ST_SAT;
        end
        num = (longint'(1) << 30) - beta * cosv;
        g = int_sqrt(longint'((longint'(1) << 30) - beta * beta) << 30);
        res = (longint'(h.energy) * longint'(num) + g / 2) / g;
        if (res > 64'd16777215) begin
            res = 64'd16777215;
            r.status = gdc_pkg::ST_SAT;
        end
        r.energy = res[gdc_pkg::OUT_BITS-1:0];
        return r;
    endfunction

    // Random hit; a mix of physical events, special geometries and energies, and noise.
    function automatic t_hit random_hit();
        t_hit h;
        int mode;
        mode = $urandom_range(9);
        h.cx = POS_W'($urandom); h.cy = POS_W'($urandom); h.cz = POS_W'($urandom);
        h.vx = POS_W'($urandom); h.vy = POS_W'($urandom); h.vz = POS_W'($urandom);
        h.tx = POS_W'($urandom); h.ty = POS_W'($urandom); h.tz = POS_W'($urandom);
        h.energy = EN_W'($urandom);
        h.beta = BETA_W'($urandom);
        case (mode)
            0, 1, 2: begin
                // Vertex near target, detector around it, track downstream.
                h.vx = POS_W'(int'($urandom_range(200)) - 100);
                h.vy = POS_W'(int'($urandom_range(200)) - 100);
                h.vz = POS_W'(int'($urandom_range(200)) - 100);
                h.cx = POS_W'(int'($urandom_range(8000)) - 4000);
                h.cy = POS_W'(int'($urandom_range(8000)) - 4000);
                h.cz = POS_W'(int'($urandom_range(8000)) - 4000);
                h.tx = POS_W'(int'($urandom_range(400)) - 200);
                h.ty = POS_W'(int'($urandom_range(400)) - 200);
                h.tz = POS_W'($urandom_range(30000));
                h.energy = EN_W'($urandom_range(160000));
                h.beta = BETA_W'(19661 + int'($urandom_range(4000)) - 2000);
            end
            3: begin
                // Simple geometry: vertex at origin, beam on +z.
                h.vx = '0; h.vy = '0; h.vz = '0;
                h.tx = '0; h.ty = '0;
                h.tz = POS_W'($urandom_range(32767, 1));
            end
            4: begin
                // Small vectors.
                h.cx = h.vx + POS_W'(int'($urandom_range(4)) - 2);
                h.cy = h.vy + POS_W'(int'($urandom_range(4)) - 2);
                h.cz = h.vz + POS_W'(int'($urandom_range(4)) - 2);
                h.tx = h.vx + POS_W'(int'($urandom_range(4)) - 2);
                h.ty = h.vy + POS_W'(int'($urandom_range(4)) - 2);
                h.tz = h.vz + POS_W'(int'($urandom_range(4)) - 2);
            end
            5: begin
                // Zero-length gamma or beam vector.
                if ($urandom_range(1)) begin
                    h.cx = h.vx; h.cy = h.vy; h.cz = h.vz + z_shift;
                end else begin
                    h.tx = h.vx; h.ty = h.vy; h.tz = h.vz;
                end
            end
            6: begin
                // Energy at the top of the range.
                h.energy = EN_W'((1 << EN_W) - 1 - int'($urandom_range(3)));
            end
            default: ;
        endcase
        return h;
    endfunction

    function automatic t_hit make_hit(input int cx, cy, cz, vx, vy, vz, tx, ty, tz,
                                      input int en, input int bt);
        t_hit h;
        h.cx = POS_W'(cx); h.cy = POS_W'(cy); h.cz = POS_W'(cz);
        h.vx = POS_W'(vx); h.vy = POS_W'(vy); h.vz = POS_W'(vz);
        h.tx = POS_W'(tx); h.ty = POS_W'(ty); h.tz = POS_W'(tz);
        h.energy = EN_W'(en);
        h.beta = BETA_W'(bt);
        return h;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hit driver: presents queued hits, random gaps unless in a steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_ch.valid <= 1'b0;
        end else begin
            if (hit_ch.valid && hit_ch.ready) begin
                expected_corr.push_back(doppler_correct(hit_on_bus));
                hits_sent++;
            end
            if (!hit_ch.valid || hit_ch.ready) begin
                if (pending_hits.size() > 0 && !hold_hits &&
                    (steady || $urandom_range(99) >= 34)) begin
                    hit_on_bus = pending_hits.pop_front();
                    hit_ch.crystal_x     <= hit_on_bus.cx;
                    hit_ch.crystal_y     <= hit_on_bus.cy;
                    hit_ch.crystal_z     <= hit_on_bus.cz;
                    hit_ch.vertex_x      <= hit_on_bus.vx;
                    hit_ch.vertex_y      <= hit_on_bus.vy;
                    hit_ch.vertex_z      <= hit_on_bus.vz;
                    hit_ch.track_x       <= hit_on_bus.tx;
                    hit_ch.track_y       <= hit_on_bus.ty;
                    hit_ch.track_z       <= hit_on_bus.tz;
                    hit_ch.lab_energy    <= hit_on_bus.energy;
                    hit_ch.beta_measured <= hit_on_bus.beta;
                    hit_ch.valid         <= 1'b1;
                end else begin
                    hit_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        t_corr want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady || ($urandom_range(99) >= 34);
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_corr.size() == 0) begin
                    $error("unexpected result transfer: corrected_energy %0d status %0d",
                           res_ch.corrected_energy, res_ch.status);
                    errors++;
                end else begin
                    want = expected_corr.pop_front();
                    if (want.status == gdc_pkg::ST_ZERO) zero_seen++;
                    if (want.status == gdc_pkg::ST_SAT) sat_seen++;
                    if (res_ch.corrected_energy !== want.energy) begin
                        $error("corrected_energy expected %0d actual %0d",
                               want.energy, res_ch.corrected_energy);
                        errors++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, res_ch.status);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((hit_ch.valid && hit_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register write, only issued while nothing is in flight.
    task automatic write_reg(input gdc_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gdc_pkg::CFG_BETA_MEAN:     mean_beta = val[BETA_W-1:0];
            gdc_pkg::CFG_BETA_TOF_MEAN: tof_beta  = val[BETA_W-1:0];
            default:                    z_shift   = val;
        endcase
    endtask

    task automatic drain();
        wait (pending_hits.size() == 0 && !hit_ch.valid && expected_corr.size() == 0);
        @(posedge i_clk);
    endtask

    // Sequence of configuration phases and stimulus.
    initial begin
        int phase_cfg [6][3];
        phase_cfg = '{'{19661, 19661, 0}, '{0, 0, -32768}, '{32767, 0, 32767},
                      '{0, 32767, 100}, '{32767, 32767, -250}, '{25000, 12000, 4000}};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = gdc_pkg::CFG_BETA_MEAN;
        i_cfg_data   = '0;
        hit_ch.valid = 1'b0;
        hit_ch.crystal_x = '0; hit_ch.crystal_y = '0; hit_ch.crystal_z = '0;
        hit_ch.vertex_x  = '0; hit_ch.vertex_y  = '0; hit_ch.vertex_z  = '0;
        hit_ch.track_x   = '0; hit_ch.track_y   = '0; hit_ch.track_z   = '0;
        hit_ch.lab_energy = '0;
        hit_ch.beta_measured = '0;
        res_ch.ready = 1'b0;
        mean_beta = gdc_pkg::BETA_RESET;
        tof_beta  = gdc_pkg::BETA_RESET;
        z_shift   = '0;
        steady = 1'b0;
        hold_hits = 1'b0;
        errors = 0;
        hits_sent = 0;
        results_seen = 0;
        zero_seen = 0;
        sat_seen = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed hits under the reset configuration.
        pending_hits.push_back(make_hit(0, 0, 0, 0, 0, 0, 0, 0, 100, 1000, 1000));
        pending_hits.push_back(make_hit(50, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 1000));
        pending_hits.push_back(make_hit(0, 0, 500, 0, 0, 0, 0, 0, 500, 16000, 19661));
        pending_hits.push_back(make_hit(0, 0, -500, 0, 0, 0, 0, 0, 500, 16000, 19661));
        pending_hits.push_back(make_hit(500, 0, 0, 0, 0, 0, 0, 0, 500, 16000, 19661));
        pending_hits.push_back(make_hit(32767, 32767, 32767, -32768, -32768, -32768,
                                        -32768, -32768, -32768, 1048575, 32767));
        pending_hits.push_back(make_hit(-32768, -32768, -32768, 32767, 32767, 32767,
                                        32767, 32767, 32767, 1048575, 32767));
        pending_hits.push_back(make_hit(0, 0, -32768, 0, 0, 32767, 0, 0, -32768,
                                        1048575, 32767));
        pending_hits.push_back(make_hit(0, 0, 32767, 0, 0, -32768, 0, 0, 32767,
                                        1048575, 32767));
        pending_hits.push_back(make_hit(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        pending_hits.push_back(make_hit(1, 1, 1, 0, 0, 0, 1, 1, 1, 1, 0));
        pending_hits.push_back(make_hit(3000, -2000, 1000, 0, 0, 0, 0, 0, 32767,
                                        1048575, 20000));
        pending_hits.push_back(make_hit(-1, -1, -1, 0, 0, 0, 32767, 32767, 32767,
                                        524288, 16384));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(gdc_pkg::CFG_BETA_MEAN, CFG_W'(phase_cfg[ph][0]));
                write_reg(gdc_pkg::CFG_BETA_TOF_MEAN, CFG_W'(phase_cfg[ph][1]));
                write_reg(gdc_pkg::CFG_DECAY_SHIFT_Z, CFG_W'(phase_cfg[ph][2]));
            end
            steady = (ph == 2);
            for (int n = 0; n < 190; n++) pending_hits.push_back(random_hit());
            // In phase 3, let the pipeline empty partway through before resuming.
            wait (pending_hits.size() < 95);
            if (ph == 3) begin
                hold_hits = 1'b1;
                wait (!hit_ch.valid && expected_corr.size() == 0);
                hold_hits = 1'b0;
            end
            drain();
        end

        repeat (150) @(posedge i_clk);
        $display("Covered %0d hits over 6 register settings with random stalls.",
                 hits_sent);
        $display("Checked %0d results: %0d zero-length, %0d saturated or clamped.",
                 results_seen, zero_seen, sat_seen);
        if (errors == 0 && expected_corr.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
